@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define AST_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define AST_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/lmkc_pkg.sv @@
// ----------------------------------------------------------------------------
// lmkc_pkg
// Types and constants of the LED mode key controller.
// ----------------------------------------------------------------------------
package lmkc_pkg;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHASE_PERIOD = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BREATH_STEP  = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BRIGHT_STEPS = 8'd3;

    localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [15:0] CHASE_PERIOD_RST = 16'd300;
    localparam logic [15:0] BREATH_STEP_RST  = 16'd10;
    localparam logic [6:0]  BRIGHT_STEPS_RST = 7'd100;

    localparam logic [3:0] ALL_LEDS = 4'hF;

    typedef enum logic [1:0] {
        MODE_STANDBY = 2'd0,
        MODE_CHASE   = 2'd1,
        MODE_BREATH  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [15:0] long_press_ms;
        logic [15:0] chase_period_ms;
        logic [15:0] breath_step_ms;
        logic [6:0]  brightness_steps;
    } lmkc_cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic        key_prev;
        logic        long_reported;
        logic [31:0] press_time;
        logic [31:0] chase_time;
        logic [1:0]  chase_index;
        logic [6:0]  glow_level;
        logic        breath_rising;
        logic [31:0] breath_time;
        logic [6:0]  pwm_phase;
        logic [3:0]  pin_levels;
    } lmkc_state_t;

    typedef struct packed {
        mode_t      mode;
        logic       beep;
        logic [3:0] led_pins;
    } lmkc_result_t;

endpackage

@@ rtl/led_mode_key_controller.sv @@
// ----------------------------------------------------------------------------
// led_mode_key_controller
// Key driven LED mode controller with chase and breathing effects.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transfer per control pass, carrying the key level and the
//   millisecond time. m_ channel: one result transfer per input transfer with
//   the held LED pins, the beep request and the mode after that pass.
//   cfg channel: register writes (index 0 long press, 1 chase period,
//   2 breath step, 3 brightness steps), always ready; the user must write
//   registers only while idle; the block itself does not enforce it. A
//   pass goes through the input register, then the result register.
//   Throughput: one transfer per cycle unless stalled; the state update is a
//   single pass of compares and counters between input and result registers.
//   Reset: synchronous active low aresetn empties both registers, returns to
//   standby with all LEDs off and loads the default register values.
//   Stall: while m_tready is low the result holds; at most one more input
//   transfer is taken into the input register, after which s_tready drops.
// ----------------------------------------------------------------------------
module led_mode_key_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: key_pressed [0], now_ms [32:1], zero fill [39:33]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [39:0]                       s_tdata,
    // m_tdata: led_pins [3:0], beep [4], mode [6:5], zero fill [7]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lmkc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lmkc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lmkc_pkg::*;

    logic         in_valid_reg;
    logic         in_key_reg;
    logic [31:0]  in_now_reg;
    logic         out_valid_reg;
    lmkc_result_t out_data_reg;
    lmkc_result_t result;
    lmkc_cfg_t    cfg_reg;
    logic         step;

    assign step      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ms    <= LONG_PRESS_RST;
            cfg_reg.chase_period_ms  <= CHASE_PERIOD_RST;
            cfg_reg.breath_step_ms   <= BREATH_STEP_RST;
            cfg_reg.brightness_steps <= BRIGHT_STEPS_RST;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_LONG_PRESS:   cfg_reg.long_press_ms    <= cfg_data;
                CFG_CHASE_PERIOD: cfg_reg.chase_period_ms  <= cfg_data;
                CFG_BREATH_STEP:  cfg_reg.breath_step_ms   <= cfg_data;
                CFG_BRIGHT_STEPS: cfg_reg.brightness_steps <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_key_reg <= s_tdata[0];
            in_now_reg <= s_tdata[32:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= result;
        end
    end

    lmkc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .key_pressed (in_key_reg),
        .now_ms      (in_now_reg),
        .cfg         (cfg_reg),
        .result      (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg.mode, out_data_reg.beep, out_data_reg.led_pins};

endmodule

@@ rtl/lmkc_core.sv @@
// ----------------------------------------------------------------------------
// lmkc_core
// Key handling and light effect state, one update per transfer.
// ----------------------------------------------------------------------------
module lmkc_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic                  key_pressed,
    input  logic [31:0]           now_ms,
    input  lmkc_pkg::lmkc_cfg_t   cfg,
    output lmkc_pkg::lmkc_result_t result
);
    import lmkc_pkg::*;

    lmkc_state_t st_reg;
    lmkc_state_t st_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{mode: MODE_STANDBY, breath_rising: 1'b1, default: '0};
        end else if (step) begin
            st_reg <= st_next;
        end
    end

    always_comb begin
        logic        rise;
        logic        beep;
        logic [31:0] hold_ms;
        logic [31:0] chase_ms;
        logic [31:0] breath_ms;
        logic [6:0]  phase;

        st_next = st_reg;
        beep    = 1'b0;

        // key handling
        rise = key_pressed && !st_reg.key_prev;
        if (rise) begin
            st_next.press_time    = now_ms;
            st_next.long_reported = 1'b0;
        end
        hold_ms = now_ms - st_next.press_time;
        if (key_pressed && !st_next.long_reported &&
                hold_ms >= {16'd0, cfg.long_press_ms}) begin
            st_next.mode          = MODE_CHASE;
            st_next.long_reported = 1'b1;
            beep                  = 1'b1;
        end
        if (!key_pressed && st_reg.key_prev && !st_next.long_reported) begin
            st_next.mode = (st_next.mode == MODE_BREATH) ? MODE_CHASE : MODE_BREATH;
            beep         = 1'b1;
        end

        // light effect
        chase_ms  = now_ms - st_reg.chase_time;
        breath_ms = now_ms - st_reg.breath_time;
        phase     = st_reg.pwm_phase + 7'd1;
        case (st_next.mode)
            MODE_CHASE: begin
                if (chase_ms >= {16'd0, cfg.chase_period_ms}) begin
                    st_next.chase_time  = now_ms;
                    st_next.pin_levels  = 4'b0001 << st_reg.chase_index;
                    st_next.chase_index = st_reg.chase_index + 2'd1;
                end
            end
            MODE_BREATH: begin
                if (breath_ms >= {16'd0, cfg.breath_step_ms}) begin
                    st_next.breath_time = now_ms;
                    if (st_reg.breath_rising) begin
                        if (st_reg.glow_level < cfg.brightness_steps) begin
                            st_next.glow_level = st_reg.glow_level + 7'd1;
                        end else begin
                            st_next.breath_rising = 1'b0;
                        end
                    end else begin
                        if (st_reg.glow_level != 7'd0) begin
                            st_next.glow_level = st_reg.glow_level - 7'd1;
                        end else begin
                            st_next.breath_rising = 1'b1;
                        end
                    end
                end
                if (phase >= cfg.brightness_steps) begin
                    phase = 7'd0;
                end
                st_next.pwm_phase  = phase;
                st_next.pin_levels = (phase < st_next.glow_level) ? ALL_LEDS : 4'd0;
            end
            default: begin
                st_next.pin_levels = 4'd0;
            end
        endcase

        st_next.key_prev = key_pressed;

        result.led_pins = st_next.pin_levels;
        result.beep     = beep;
        result.mode     = st_next.mode;
    end

endmodule

@@ rtl/lmkc_checker.sv @@
// ----------------------------------------------------------------------------
// lmkc_checker
// Port level checks of the LED mode key controller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lmkc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [39:0]                       s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [7:0]                        m_tdata,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [lmkc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input logic [lmkc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lmkc_pkg::*;

    `AST_CLK_ALWAYS(a_no_result_after_reset, aclk, !aresetn |=> !m_tvalid, "result after reset")

    `AST_CLK(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled transfer changed")

    `AST_CLK(a_mode_legal, aclk, aresetn, m_tvalid |-> m_tdata[6:5] != 2'd3 && !m_tdata[7], "illegal mode or fill bit")

    `AST_CLK(a_standby_dark, aclk, aresetn, m_tvalid && m_tdata[6:5] == MODE_STANDBY |-> m_tdata[3:0] == 4'd0, "leds lit in standby")

    `AST_CLK(a_breath_all_or_none, aclk, aresetn, m_tvalid && m_tdata[6:5] == MODE_BREATH |-> m_tdata[3:0] == 4'd0 || m_tdata[3:0] == ALL_LEDS, "partial leds while breathing")

endmodule

bind led_mode_key_controller lmkc_checker u_lmkc_checker (.*);

@@ dv/lmkc_pass_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lmkc_pass_checker
// Watches the pass, result and register channels of the LED mode key
// controller. It predicts the LED pins, beep and mode of every pass and
// checks each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module lmkc_pass_checker
    import lmkc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [39:0]             s_tdata,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [7:0]              m_tdata,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output int                      pending_results,
    output int                      fail_count
);

    lmkc_cfg_t    ctrl_cfg;
    lmkc_state_t  ctrl_state;
    lmkc_result_t expected_results[$];
    int           mismatches = 0;

    function automatic lmkc_result_t predict_pass(input logic key, input logic [31:0] now_ms);
        lmkc_result_t res;
        logic [31:0]  elapsed;
        res.beep = 1'b0;

        // key handling: press edge, long hold, short release
        if (key && !ctrl_state.key_prev) begin
            ctrl_state.press_time    = now_ms;
            ctrl_state.long_reported = 1'b0;
        end
        elapsed = now_ms - ctrl_state.press_time;
        if (key && !ctrl_state.long_reported && elapsed >= {16'd0, ctrl_cfg.long_press_ms}) begin
            ctrl_state.mode          = MODE_CHASE;
            ctrl_state.long_reported = 1'b1;
            res.beep                 = 1'b1;
        end
        if (!key && ctrl_state.key_prev && !ctrl_state.long_reported) begin
            ctrl_state.mode = (ctrl_state.mode == MODE_BREATH) ? MODE_CHASE : MODE_BREATH;
            res.beep        = 1'b1;
        end

        // light effect of the resulting mode
        case (ctrl_state.mode)
            MODE_CHASE: begin
                elapsed = now_ms - ctrl_state.chase_time;
                if (elapsed >= {16'd0, ctrl_cfg.chase_period_ms}) begin
                    ctrl_state.chase_time  = now_ms;
                    ctrl_state.pin_levels  = 4'b0001 << ctrl_state.chase_index;
                    ctrl_state.chase_index = ctrl_state.chase_index + 2'd1;
                end
            end
            MODE_BREATH: begin
                elapsed = now_ms - ctrl_state.breath_time;
                if (elapsed >= {16'd0, ctrl_cfg.breath_step_ms}) begin
                    ctrl_state.breath_time = now_ms;
                    if (ctrl_state.breath_rising) begin
                        if (ctrl_state.glow_level < ctrl_cfg.brightness_steps)
                            ctrl_state.glow_level = ctrl_state.glow_level + 7'd1;
                        else
                            ctrl_state.breath_rising = 1'b0;
                    end else begin
                        if (ctrl_state.glow_level > 7'd0)
                            ctrl_state.glow_level = ctrl_state.glow_level - 7'd1;
                        else
                            ctrl_state.breath_rising = 1'b1;
                    end
                end
                ctrl_state.pwm_phase = ctrl_state.pwm_phase + 7'd1;
                if (ctrl_state.pwm_phase >= ctrl_cfg.brightness_steps)
                    ctrl_state.pwm_phase = 7'd0;
                ctrl_state.pin_levels =
                    (ctrl_state.pwm_phase < ctrl_state.glow_level) ? ALL_LEDS : 4'h0;
            end
            default: begin
                ctrl_state.pin_levels = 4'h0;
            end
        endcase

        ctrl_state.key_prev = key;
        res.led_pins = ctrl_state.pin_levels;
        res.mode     = ctrl_state.mode;
        return res;
    endfunction

    always @(posedge aclk) begin : monitor
        lmkc_result_t want;
        logic         bad;
        if (!aresetn) begin
            ctrl_cfg = '{long_press_ms: LONG_PRESS_RST, chase_period_ms: CHASE_PERIOD_RST,
                         breath_step_ms: BREATH_STEP_RST, brightness_steps: BRIGHT_STEPS_RST};
            ctrl_state               = '0;
            ctrl_state.mode          = MODE_STANDBY;
            ctrl_state.breath_rising = 1'b1;
            expected_results.delete();
        end else begin
            // compare before predicting so a result never meets its own pass
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transfer with none expected, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    bad  = 1'b0;
                    if (m_tdata[3:0] !== want.led_pins) begin
                        $display("%0t: led_pins expected %h actual %h",
                                 $time, want.led_pins, m_tdata[3:0]);
                        bad = 1'b1;
                    end
                    if (m_tdata[4] !== want.beep) begin
                        $display("%0t: beep expected %b actual %b",
                                 $time, want.beep, m_tdata[4]);
                        bad = 1'b1;
                    end
                    if (m_tdata[6:5] !== want.mode) begin
                        $display("%0t: mode expected %0d actual %0d",
                                 $time, want.mode, m_tdata[6:5]);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatches++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_LONG_PRESS:   ctrl_cfg.long_press_ms    = cfg_data;
                    CFG_CHASE_PERIOD: ctrl_cfg.chase_period_ms  = cfg_data;
                    CFG_BREATH_STEP:  ctrl_cfg.breath_step_ms   = cfg_data;
                    CFG_BRIGHT_STEPS: ctrl_cfg.brightness_steps = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_pass(s_tdata[0], s_tdata[32:1]));
        end
        pending_results <= expected_results.size();
        fail_count      <= mismatches;
    end

endmodule

@@ dv/led_mode_key_controller_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_mode_key_controller_tb
// Drives key level and millisecond time passes into the LED mode key
// controller: a directed sequence of presses, long holds and timer wraps,
// then random key runs and time steps under several register settings,
// with random gaps and back-pressure. A checker module predicts and compares.
// ----------------------------------------------------------------------------
module led_mode_key_controller_tb;
    import lmkc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int          pending_results;
    int          fail_count;
    int          quiet_cycles = 0;
    int          stall_left   = 0;
    bit          tx_idle      = 1'b0;
    bit          rx_idle      = 1'b0;
    logic [31:0] now_ms       = '0;
    bit          key_level    = 1'b0;
    int          key_run      = 0;

    led_mode_key_controller i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    lmkc_pass_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side back-pressure in bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("led_mode_key_controller_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic send_pass(input logic key, input logic [31:0] t);
        if (tx_idle && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, t, key};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic write_cfg(input logic [15:0] long_press, input logic [15:0] chase_period,
                             input logic [15:0] breath_step, input logic [6:0] bright_steps);
        write_reg(CFG_LONG_PRESS, long_press);
        write_reg(CFG_CHASE_PERIOD, chase_period);
        write_reg(CFG_BREATH_STEP, breath_step);
        write_reg(CFG_BRIGHT_STEPS, {9'd0, bright_steps});
        cfg_valid <= 1'b0;
    endtask

    // key held or released in runs, with single-pass glitches; time moves in
    // steps around the hint, sometimes stands still or jumps anywhere
    task automatic run_passes(input int count, input int unsigned hint);
        int unsigned r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                now_ms += $urandom_range(1, hint);
            else if (r < 85)
                now_ms += $urandom_range(0, 3 * hint);
            else if (r >= 95)
                now_ms = $urandom;
            if (key_run == 0) begin
                key_level = !key_level;
                key_run   = key_level ? $urandom_range(1, 6) : $urandom_range(1, 8);
            end
            key_run--;
            send_pass(($urandom_range(0, 19) == 0) ? !key_level : key_level, now_ms);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle <= 1'b1;
        rx_idle <= 1'b1;
        @(posedge aclk);

        // directed passes under the reset register values
        send_pass(1'b0, 32'h0000_0000);
        send_pass(1'b0, 32'hFFFF_FFFF);
        send_pass(1'b1, 32'h0000_0010);
        send_pass(1'b0, 32'h0000_0050);
        send_pass(1'b0, 32'h0000_005A);
        send_pass(1'b0, 32'h0000_0064);
        send_pass(1'b1, 32'h0000_0100);
        send_pass(1'b1, 32'h0000_04E8);
        send_pass(1'b1, 32'h0000_0600);
        send_pass(1'b0, 32'h0000_0700);
        send_pass(1'b0, 32'h0000_0900);
        send_pass(1'b0, 32'h0000_0A2C);
        send_pass(1'b1, 32'h0000_0B00);
        send_pass(1'b0, 32'h0000_0B01);
        send_pass(1'b1, 32'hFFFF_FF00);
        send_pass(1'b1, 32'h0000_02E8);
        send_pass(1'b0, 32'h0000_0300);
        send_pass(1'b1, 32'h0000_0310);
        send_pass(1'b0, 32'h0000_0320);
        send_pass(1'b0, 32'h8000_0000);
        now_ms = 32'h8000_0000;

        drain_results();
        write_cfg(16'd1, 16'd1, 16'd1, 7'd1);
        rx_idle <= 1'b0;
        run_passes(150, 3);

        drain_results();
        write_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127);
        rx_idle <= 1'b1;
        run_passes(200, 131070);

        drain_results();
        write_cfg(16'($urandom_range(1, 60)), 16'($urandom_range(1, 30)),
                  16'($urandom_range(1, 8)), 7'($urandom_range(1, 12)));
        tx_idle <= 1'b0;
        run_passes(250, 20);

        drain_results();
        write_cfg(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                  16'($urandom_range(1, 65535)), 7'($urandom_range(1, 127)));
        tx_idle <= 1'b1;
        run_passes(200, 20000);

        drain_results();
        write_cfg(16'($urandom_range(1, 60)), 16'($urandom_range(1, 30)),
                  16'($urandom_range(1, 8)), 7'($urandom_range(1, 12)));
        tx_idle <= 1'b0;
        rx_idle <= 1'b0;
        run_passes(230, 20);

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("led_mode_key_controller_tb OK");
        else
            $display("led_mode_key_controller_tb NOT OK");
        $finish;
    end

endmodule
